// ===== rtl/safs_pkg.sv =====
// shared constants and codes for the slot allocator
`timescale 1ns / 1ps
package safs_pkg;

  localparam int FUNC_W     = 2;
  localparam int SLOT_W     = 16;
  localparam int VIEW_W     = 64;
  localparam int SLOT_OUT_W = 10;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 11;
  localparam int FALLBACK_W = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FALLBACK = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd3;

endpackage

// ===== rtl/safs_req_if.sv =====
// request channel: operation, slot index and view handle
`timescale 1ns / 1ps
interface safs_req_if;
  import safs_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SLOT_W-1:0] slot;
  logic [VIEW_W-1:0] view;

  modport source (output valid, func, slot, view, input ready);
  modport sink (input valid, func, slot, view, output ready);
endinterface

// ===== rtl/safs_rsp_if.sv =====
// response channel: slot, status, validity and used count
`timescale 1ns / 1ps
interface safs_rsp_if;
  import safs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SLOT_OUT_W-1:0] slot_out;
  logic [STATUS_W-1:0]   status;
  logic                  is_valid;
  logic [COUNT_W-1:0]    used_count;

  modport source (output valid, slot_out, status, is_valid, used_count, input ready);
  modport sink (input valid, slot_out, status, is_valid, used_count, output ready);
endinterface

// ===== rtl/safs_ram.sv =====
// simple dual port ram, one write port, one registered read port
`timescale 1ns / 1ps
module safs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/slot_allocator_free_stack.sv =====
// slot allocator top level: free stack plus bump pointer over a slot table
// usage
//   req channel carries func, slot and view; an item is taken when valid and
//   ready are high at a clock edge. ready is low only while an item sits in
//   the read stage. each item first reads the view table and the free stack
//   (both synchronous rams), then decides, writes back and loads the result
//   register, and no new item is taken until the last one has left the
//   read stage. rsp carries slot_out, status, is_valid and used_count from
//   an output register, loaded as the item leaves the read stage.
//   if the receiver stalls, the result is held; one more item may be taken
//   and waits in the read stage until the result register is freed.
//   cfg_we/cfg_wdata write the fallback slot; the user must do so only while
//   the block is idle, the block does not enforce it.
//   reset is synchronous: counters restart, fallback slot goes to zero.
//   no clearing pass: slots at or above the bump pointer read as absent, and
//   the reserved slots are present by rule, so table contents below the bump
//   pointer are always written before they are read.
`timescale 1ns / 1ps
module slot_allocator_free_stack #(
  parameter int NUM_SLOTS = 1024,
  parameter int RESERVED  = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [safs_pkg::FALLBACK_W-1:0] cfg_wdata,
  safs_req_if.sink                      req,
  safs_rsp_if.source                    rsp
);
  import safs_pkg::*;

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int TOP_W = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W = SLOT_W + 1;
  localparam logic [CMP_W-1:0]  NUM_SLOTS_C = CMP_W'(NUM_SLOTS);
  localparam logic [CMP_W-1:0]  RESERVED_C  = CMP_W'(RESERVED);
  localparam logic [TOP_W-1:0]  TOP_MAX     = TOP_W'(NUM_SLOTS);

  // configuration
  logic [FALLBACK_W-1:0] fallback_slot;

  // allocator counters
  logic [TOP_W-1:0] free_top, free_top_next;
  logic [TOP_W-1:0] next_fresh, next_fresh_next;
  logic [TOP_W-1:0] alloc_count, alloc_count_next;

  // read stage
  logic              busy;
  logic [FUNC_W-1:0] pend_func;
  logic [SLOT_W-1:0] pend_slot;
  logic [VIEW_W-1:0] pend_view;

  // result register
  logic                  out_valid;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_is_valid;
  logic [COUNT_W-1:0]    out_count;

  // ram ports
  logic              view_we;
  logic [IDX_W-1:0]  view_waddr;
  logic [VIEW_W-1:0] view_wdata;
  logic [VIEW_W-1:0] view_rdata;
  logic              stack_we;
  logic [IDX_W-1:0]  stack_waddr;
  logic [IDX_W-1:0]  stack_wdata;
  logic [IDX_W-1:0]  stack_rdata;
  logic [TOP_W-1:0]  top_minus1;

  logic accept;
  logic fire;

  // decision signals
  logic [CMP_W-1:0]  slot_ext;
  logic              in_range;
  logic              is_reserved;
  logic              below_fresh;
  logic              present;
  logic [IDX_W-1:0]  pend_idx;
  logic [IDX_W-1:0]  alloc_idx;
  logic [SLOT_OUT_W-1:0] res_slot;
  logic [STATUS_W-1:0]   res_status;
  logic                  res_is_valid;
  logic [31:0]           slot_wide;
  logic [31:0]           count_wide;

  assign accept    = req.valid && req.ready;
  assign fire      = busy && (!out_valid || rsp.ready);
  assign req.ready = !busy;

  // stack read at top-1, issued with the item; top only moves in write-back
  assign top_minus1 = free_top - 1'b1;

  safs_ram #(.WIDTH(VIEW_W), .DEPTH(NUM_SLOTS)) u_view_ram (
    .clk   (clk),
    .we    (view_we),
    .waddr (view_waddr),
    .wdata (view_wdata),
    .re    (accept),
    .raddr (req.slot[IDX_W-1:0]),
    .rdata (view_rdata)
  );

  safs_ram #(.WIDTH(IDX_W), .DEPTH(NUM_SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .re    (accept),
    .raddr (top_minus1[IDX_W-1:0]),
    .rdata (stack_rdata)
  );

  // slot checks for free and query
  assign slot_ext    = CMP_W'(pend_slot);
  assign in_range    = slot_ext < NUM_SLOTS_C;
  assign is_reserved = slot_ext < RESERVED_C;
  assign below_fresh = slot_ext < CMP_W'(next_fresh);
  assign pend_idx    = pend_slot[IDX_W-1:0];
  // a live slot always holds a non-null handle, freed slots hold zero
  assign present     = in_range && (is_reserved || (below_fresh && (view_rdata != '0)));

  // write-back decision
  always_comb begin
    free_top_next    = free_top;
    next_fresh_next  = next_fresh;
    alloc_count_next = alloc_count;
    view_we          = 1'b0;
    view_waddr       = pend_idx;
    view_wdata       = '0;
    stack_we         = 1'b0;
    stack_waddr      = free_top[IDX_W-1:0];
    stack_wdata      = pend_idx;
    alloc_idx        = next_fresh[IDX_W-1:0];
    res_slot         = '0;
    res_status       = ST_DONE;
    res_is_valid     = 1'b0;
    slot_wide        = '0;
    case (pend_func)
      FUNC_ALLOC: begin
        if (pend_view == '0) begin
          res_slot   = SLOT_OUT_W'(fallback_slot);
          res_status = ST_FALLBACK;
        end else if (free_top != '0) begin
          // reuse the most recently freed slot
          alloc_idx     = stack_rdata;
          free_top_next = top_minus1;
        end else if (next_fresh >= TOP_MAX) begin
          res_status = ST_FULL;
        end else begin
          next_fresh_next = next_fresh + 1'b1;
        end
        if ((pend_view != '0) && ((free_top != '0) || (next_fresh < TOP_MAX))) begin
          view_we          = fire;
          view_waddr       = alloc_idx;
          view_wdata       = pend_view;
          alloc_count_next = alloc_count + 1'b1;
          slot_wide        = 32'(alloc_idx);
          res_slot         = slot_wide[SLOT_OUT_W-1:0];
        end
      end
      FUNC_FREE: begin
        if (!present || is_reserved) begin
          res_status = ST_IGNORED;
        end else begin
          view_we = fire;
          if (free_top < TOP_MAX) begin
            stack_we      = fire;
            free_top_next = free_top + 1'b1;
          end
          if (alloc_count != '0) begin
            alloc_count_next = alloc_count - 1'b1;
          end
        end
      end
      FUNC_QUERY: begin
        res_is_valid = present;
      end
      default: begin
      end
    endcase
    count_wide = 32'(alloc_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fallback_slot <= '0;
      free_top      <= '0;
      next_fresh    <= TOP_W'(RESERVED);
      alloc_count   <= TOP_W'(RESERVED);
      busy          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        fallback_slot <= cfg_wdata;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (fire) begin
        busy <= 1'b0;
      end
      if (fire) begin
        free_top    <= free_top_next;
        next_fresh  <= next_fresh_next;
        alloc_count <= alloc_count_next;
        out_valid   <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_func <= req.func;
      pend_slot <= req.slot;
      pend_view <= req.view;
    end
    if (fire) begin
      out_slot     <= res_slot;
      out_status   <= res_status;
      out_is_valid <= res_is_valid;
      out_count    <= count_wide[COUNT_W-1:0];
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.slot_out   = out_slot;
  assign rsp.status     = out_status;
  assign rsp.is_valid   = out_is_valid;
  assign rsp.used_count = out_count;

endmodule

// ===== tb/sv/slot_allocator_free_stack_tb.sv =====
// self-checking testbench for the slot allocator: directed table, random traffic, scoreboard
`timescale 1ns / 1ps
module slot_allocator_free_stack_tb;
  import safs_pkg::*;

  localparam int NUM_SLOTS = 1024;
  localparam int RESERVED  = 4;

  // the package names only the three live operations; code 3 is a no-op
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [VIEW_W-1:0] HANDLE_BASE = 64'h100;

  localparam int MAX_WAIT    = 13;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot_out;
    logic [STATUS_W-1:0]   status;
    logic                  is_valid;
    logic [COUNT_W-1:0]    used_count;
  } alloc_result_t;

  // one row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot;
    logic [VIEW_W-1:0] view;
    logic              typed;
    alloc_result_t     want;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [FALLBACK_W-1:0] cfg_wdata = '0;

  safs_req_if req ();
  safs_rsp_if rsp ();

  slot_allocator_free_stack #(
    .NUM_SLOTS(NUM_SLOTS),
    .RESERVED (RESERVED)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // allocator shadow state: presence bits, handles, recycle stack, bump pointer
  // ---------------------------------------------------------------------------
  bit                    slot_live   [NUM_SLOTS];
  logic [VIEW_W-1:0]     slot_handle [NUM_SLOTS];
  logic [SLOT_OUT_W-1:0] recycled    [NUM_SLOTS];
  int unsigned           recycled_top;
  int unsigned           bump_ptr;
  int unsigned           live_count;
  logic [FALLBACK_W-1:0] fallback_sel;

  // results still owed by the block, oldest first
  alloc_result_t pending_results [$];
  int unsigned   mismatches = 0;

  // directed part, run straight after reset with the fallback slot at zero
  stim_row_t directed_rows [25] = '{
    // reserved slots are present from reset, fresh ones are not
    '{FUNC_QUERY, 16'd0,     64'd0, 1'b1, '{10'd0, ST_DONE, 1'b1, 11'd4}},
    '{FUNC_QUERY, 16'd3,     64'd0, 1'b1, '{10'd0, ST_DONE, 1'b1, 11'd4}},
    '{FUNC_QUERY, 16'd4,     64'd0, 1'b1, '{10'd0, ST_DONE, 1'b0, 11'd4}},
    // queries out of range
    '{FUNC_QUERY, 16'hFFFF,  64'd0, 1'b1, '{10'd0, ST_DONE, 1'b0, 11'd4}},
    '{FUNC_QUERY, 16'd1024,  64'd0, 1'b1, '{10'd0, ST_DONE, 1'b0, 11'd4}},
    // null handle hands back the fallback slot
    '{FUNC_ALLOC, 16'd9,     64'd0, 1'b1, '{10'd0, ST_FALLBACK, 1'b0, 11'd4}},
    // frees of reserved, absent and out-of-range slots are ignored
    '{FUNC_FREE,  16'd0,     64'd0, 1'b1, '{10'd0, ST_IGNORED, 1'b0, 11'd4}},
    '{FUNC_FREE,  16'd3,     64'd0, 1'b1, '{10'd0, ST_IGNORED, 1'b0, 11'd4}},
    '{FUNC_FREE,  16'd4,     64'd0, 1'b1, '{10'd0, ST_IGNORED, 1'b0, 11'd4}},
    '{FUNC_FREE,  16'hFFFF,  64'd0, 1'b1, '{10'd0, ST_IGNORED, 1'b0, 11'd4}},
    '{FUNC_FREE,  16'd1024,  64'd0, 1'b1, '{10'd0, ST_IGNORED, 1'b0, 11'd4}},
    // bump pointer hands out slots 4, 5, 6
    '{FUNC_ALLOC, 16'hFFFF,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{10'd4, ST_DONE, 1'b0, 11'd5}},
    '{FUNC_ALLOC, 16'd0,     64'h1, 1'b1, '{10'd5, ST_DONE, 1'b0, 11'd6}},
    '{FUNC_ALLOC, 16'd0,     64'h8000_0000_0000_0000, 1'b1, '{10'd6, ST_DONE, 1'b0, 11'd7}},
    '{FUNC_QUERY, 16'd4,     64'd0, 1'b1, '{10'd0, ST_DONE, 1'b1, 11'd7}},
    '{FUNC_FREE,  16'd5,     64'd0, 1'b1, '{10'd0, ST_DONE, 1'b0, 11'd6}},
    '{FUNC_QUERY, 16'd5,     64'd0, 1'b1, '{10'd0, ST_DONE, 1'b0, 11'd6}},
    // double free is ignored
    '{FUNC_FREE,  16'd5,     64'd0, 1'b1, '{10'd0, ST_IGNORED, 1'b0, 11'd6}},
    '{FUNC_FREE,  16'd4,     64'd0, 1'b1, '{10'd0, ST_DONE, 1'b0, 11'd5}},
    // recycled slots come back last in, first out, then the bump pointer resumes
    '{FUNC_ALLOC, 16'd0,     64'h0123_4567_89AB_CDEF, 1'b1, '{10'd4, ST_DONE, 1'b0, 11'd6}},
    '{FUNC_ALLOC, 16'd0,     64'hFEDC_BA98_7654_3210, 1'b1, '{10'd5, ST_DONE, 1'b0, 11'd7}},
    '{FUNC_ALLOC, 16'd0,     64'h5555_AAAA_5555_AAAA, 1'b1, '{10'd7, ST_DONE, 1'b0, 11'd8}},
    // unused code changes nothing
    '{FUNC_UNUSED, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{10'd0, ST_DONE, 1'b0, 11'd8}},
    '{FUNC_QUERY, 16'd7,     64'd0, 1'b0, '0},
    '{FUNC_FREE,  16'd7,     64'd0, 1'b0, '0}
  };

  function automatic void table_reset();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_live[i]   = (i < RESERVED);
      slot_handle[i] = (i < RESERVED) ? HANDLE_BASE + VIEW_W'(i) : '0;
      recycled[i]    = '0;
    end
    recycled_top = 0;
    bump_ptr     = RESERVED;
    live_count   = RESERVED;
    fallback_sel = '0;
  endfunction

  // applies one accepted item to the shadow state and returns what the block owes
  function automatic alloc_result_t predict_item(input logic [FUNC_W-1:0] func,
                                                 input logic [SLOT_W-1:0] slot,
                                                 input logic [VIEW_W-1:0] view);
    alloc_result_t res;
    int unsigned   s;
    res = '0;
    case (func)
      FUNC_ALLOC: begin
        if (view == '0) begin
          res.slot_out = SLOT_OUT_W'(fallback_sel);
          res.status   = ST_FALLBACK;
        end else if (recycled_top == 0 && bump_ptr >= NUM_SLOTS) begin
          res.status = ST_FULL;
        end else begin
          if (recycled_top > 0) begin
            recycled_top--;
            s = recycled[recycled_top];
          end else begin
            s = bump_ptr;
            bump_ptr++;
          end
          slot_handle[s] = view;
          slot_live[s]   = 1'b1;
          live_count++;
          res.slot_out = s[SLOT_OUT_W-1:0];
          res.status   = ST_DONE;
        end
      end
      FUNC_FREE: begin
        if (slot < RESERVED || slot >= NUM_SLOTS || !slot_live[slot]) begin
          res.status = ST_IGNORED;
        end else begin
          slot_live[slot]   = 1'b0;
          slot_handle[slot] = '0;
          // stack overflow cannot happen: it only ever holds distinct absent slots
          if (recycled_top < NUM_SLOTS) begin
            recycled[recycled_top] = slot[SLOT_OUT_W-1:0];
            recycled_top++;
          end
          if (live_count > 0) live_count--;
          res.status = ST_DONE;
        end
      end
      FUNC_QUERY: begin
        res.is_valid = (slot < NUM_SLOTS) && slot_live[slot] && (slot_handle[slot] != '0);
      end
      default: ;
    endcase
    res.used_count = COUNT_W'(live_count);
    return res;
  endfunction

  // wait before an item; every fourth stretch of 40 items runs with no idling
  function automatic int unsigned draw_wait(input int unsigned seq);
    if ((seq / 40) % 4 == 3) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // slot for free and query: mostly ones the bump pointer has reached
  function automatic logic [SLOT_W-1:0] pick_slot();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 6 && bump_ptr > RESERVED) return SLOT_W'($urandom_range(RESERVED, bump_ptr - 1));
    if (k < 8) return SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    if (k == 8) return SLOT_W'($urandom);
    return SLOT_W'($urandom_range(0, RESERVED - 1));
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
  endtask

  // ---------------------------------------------------------------------------
  // request side
  // valid stays high when the next item follows with no gap, so it never gets
  // two nonblocking writes in one step
  // ---------------------------------------------------------------------------
  int unsigned items_sent = 0;

  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot,
                           input logic [VIEW_W-1:0] view, input logic typed,
                           input alloc_result_t want);
    int unsigned   gap;
    alloc_result_t predicted;
    gap = draw_wait(items_sent);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func  <= func;
    req.slot  <= slot;
    req.view  <= view;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
    // the shadow state always advances, typed rows only override the expectation
    predicted = predict_item(func, slot, view);
    pending_results = {pending_results, (typed ? want : predicted)};
  endtask

  // sender holds off until the block has returned everything
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_fallback(input logic [FALLBACK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    fallback_sel = value;
  endtask

  // mixed traffic: allocs slightly outweigh frees so the table keeps filling
  task automatic random_burst(input int unsigned count);
    logic [FUNC_W-1:0] f;
    logic [SLOT_W-1:0] s;
    logic [VIEW_W-1:0] v;
    int unsigned       pick;
    alloc_result_t     none;
    none = '0;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      v    = {$urandom, $urandom};
      s    = pick_slot();
      if (pick < 42) begin
        f = FUNC_ALLOC;
        if ($urandom_range(0, 15) == 0) v = '0;
      end else if (pick < 75) begin
        f = FUNC_FREE;
      end else if (pick < 96) begin
        f = FUNC_QUERY;
      end else begin
        f = FUNC_UNUSED;
      end
      send_item(f, s, v, 1'b0, none);
    end
  endtask

  initial begin : stimulus
    alloc_result_t none;
    none      = '0;
    req.valid = 1'b0;
    req.func  = '0;
    req.slot  = '0;
    req.view  = '0;
    table_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table, fallback slot still at its reset value
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].func, directed_rows[i].slot, directed_rows[i].view,
                directed_rows[i].typed, directed_rows[i].want);
    end

    wait_drained();
    write_fallback(2'd3);
    random_burst(350);

    // null handle with a new fallback slot, then the top slot of the table
    wait_drained();
    write_fallback(2'd1);
    send_item(FUNC_ALLOC, 16'd0, 64'd0, 1'b0, none);
    send_item(FUNC_QUERY, 16'(NUM_SLOTS - 1), 64'd0, 1'b0, none);

    // more churn on a fuller table
    wait_drained();
    write_fallback(2'd2);
    random_burst(280);

    wait_drained();
    write_fallback(2'd0);
    random_burst(40);

    wait_drained();
    if (mismatches == 0) begin
      $display("[slot_allocator_free_stack] OK");
    end else begin
      $display("[slot_allocator_free_stack] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, every accepted item checked in order
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int unsigned   stall;
    int unsigned   taken;
    alloc_result_t want;
    alloc_result_t got;
    taken     = 0;
    rsp.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      // offset so the calm stretches do not line up with the sender's
      stall = draw_wait(taken + 80);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (rsp.valid !== 1'b1) @(posedge clk);
      taken++;
      got = '{rsp.slot_out, rsp.status, rsp.is_valid, rsp.used_count};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", taken));
      end else begin
        want = pending_results.pop_front();
        if (got.slot_out !== want.slot_out || got.status !== want.status ||
            got.is_valid !== want.is_valid || got.used_count !== want.used_count) begin
          report_mismatch($sformatf(
            "result %0d: slot_out %0d/%0d status %0d/%0d is_valid %0b/%0b used %0d/%0d",
            taken, got.slot_out, want.slot_out, got.status, want.status,
            got.is_valid, want.is_valid, got.used_count, want.used_count));
        end
      end
    end
  end

  // the time limit lies well above the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("[slot_allocator_free_stack] ERROR");
    $finish;
  end

endmodule
